FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gma_pkg.sv
`timescale 1ns / 1ps
// types and constants for the gated moving average
// no dependencies
package gma_pkg;

    localparam int INTENSITY_W = 16;
    localparam int TIME_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_INTERVAL = '0;
    localparam logic [TIME_W-1:0]    INTERVAL_RESET      = 32'd1000;

    typedef struct packed {
        logic [INTENSITY_W-1:0] intensity;
        logic                   accepted;
    } t_queue_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } t_back_state;

endpackage

FILE: hw/rtl/gated_moving_average.sv
`timescale 1ns / 1ps
// Time-gated moving average of light intensity samples with warm-up.
// Input channel (i_valid/o_ready): a Q0.16 intensity and a millisecond
// timestamp. A sample enters the window only when the wrapping time since
// the last entered sample exceeds the sample interval register (APB, 0x0).
// Output channel (o_valid/i_ready): one result per input transfer, the
// mean of the stored samples, whether the sample entered, and window full.
// Path: a gated-out sample passes the queue, then the result register; an entered
// one passes the queue, the ring update, the one-bit-per-cycle divider in the back
// end and a done state, then the result register. The back takes no new sample
// until an entered one is through; gated-out ones go at one per cycle while it is
// idle and each result is taken. A two-entry queue lets the front keep taking
// items while the back divides or waits on a stalled receiver.
// Reset (synchronous, active low) empties the window, clears the sum and
// last time, and sets the interval to 1000 ms; it needs no clearing pass.
// While the receiver stalls the result holds and the queue fills, after
// which o_ready drops.
// depends on gma_pkg, gma_front, gma_queue, gma_back
module gated_moving_average import gma_pkg::*; #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INTENSITY_W-1:0] i_intensity,
    input  logic [TIME_W-1:0]      i_now_ms,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [INTENSITY_W-1:0] o_average,
    output logic                   o_accepted,
    output logic                   o_window_full
);

    t_queue_entry push_entry;
    t_queue_entry head_entry;
    logic         push;
    logic         pop;
    logic         q_empty;
    logic         q_full;

    gma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_intensity  (i_intensity),
        .i_now_ms     (i_now_ms),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    gma_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gma_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average     (o_average),
        .o_accepted    (o_accepted),
        .o_window_full (o_window_full)
    );

endmodule

FILE: hw/rtl/gma_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module gma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gma_queue.sv
`timescale 1ns / 1ps
// short queue of classified samples between front and back
// depends on gma_pkg
module gma_queue import gma_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_entry i_entry,
    input  logic         i_pop,
    output t_queue_entry o_entry,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_queue_entry     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);

endmodule

FILE: hw/rtl/gma_front.sv
`timescale 1ns / 1ps
// front end: register port, time gate and sample classification
// depends on gma_pkg
module gma_front import gma_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [INTENSITY_W-1:0] i_intensity,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output t_queue_entry           o_push_entry
);

    logic [TIME_W-1:0] r_interval;
    logic [TIME_W-1:0] r_last_time;
    logic [TIME_W-1:0] elapsed;
    logic              take;
    logic              reg_hit;
    logic              cfg_write;

    assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_INTERVAL);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? r_interval : '0;

    assign elapsed = i_now_ms - r_last_time;
    assign take    = (elapsed > r_interval);

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    assign o_push_entry.intensity = i_intensity;
    assign o_push_entry.accepted  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_last_time <= '0;
        end else begin
            if (cfg_write) begin
                r_interval <= pwdata;
            end
            if (o_push && take) begin
                r_last_time <= i_now_ms;
            end
        end
    end

endmodule

FILE: hw/rtl/gma_back.sv
`timescale 1ns / 1ps
// back end: ring update, running sum, serial divide and result register
// depends on gma_pkg and gma_ram
module gma_back import gma_pkg::*; #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_queue_entry           i_entry,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [INTENSITY_W-1:0] o_average,
    output logic                   o_accepted,
    output logic                   o_window_full
);

    localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = INTENSITY_W + PTR_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_DEPTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    t_back_state r_state;
    t_back_state n_state;

    logic [PTR_W-1:0]       r_wptr;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;
    logic [INTENSITY_W-1:0] r_avg;
    logic [INTENSITY_W-1:0] r_sample;
    logic [CNT_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [STEP_W-1:0]      r_step;

    logic                   r_o_valid;
    logic [INTENSITY_W-1:0] r_o_average;
    logic                   r_o_accepted;
    logic                   r_o_full;

    logic                   out_free;
    logic                   ring_we;
    logic                   load_skip;
    logic                   load_done;
    logic                   full;
    logic [INTENSITY_W-1:0] ring_rdata;
    logic [SUM_W-1:0]       n_sum;
    logic [CNT_W:0]         partial;
    logic                   ge;
    logic [CNT_W:0]         diff;

    gma_ram #(
        .WIDTH (INTENSITY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_wptr),
        .o_rdata (ring_rdata)
    );

    assign out_free = !r_o_valid || i_ready;
    assign full     = (r_count == CNT_FULL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && i_entry.accepted) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_DIVIDE;
            ST_DIVIDE: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        ring_we   = 1'b0;
        load_skip = 1'b0;
        load_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_entry.accepted) begin
                        o_pop = 1'b1;
                    end else if (out_free) begin
                        o_pop     = 1'b1;
                        load_skip = 1'b1;
                    end
                end
            end
            ST_UPDATE: ring_we = 1'b1;
            ST_DIVIDE: ;
            ST_DONE:   load_done = out_free;
            default: ;
        endcase
    end

    // old sample leaves only once the window is full
    assign n_sum = r_sum - (full ? SUM_W'(ring_rdata) : '0) + SUM_W'(r_sample);

    assign partial = {r_rem, r_quo[SUM_W-1]};
    assign diff    = partial - {1'b0, r_count};
    assign ge      = (partial >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wptr    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_avg     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ring_we) begin
                r_sum  <= n_sum;
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                if (!full) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (load_done) begin
                r_avg <= r_quo[INTENSITY_W-1:0];
            end
            if (load_skip || load_done) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_entry.intensity;
        end
        if (ring_we) begin
            r_quo  <= n_sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == ST_DIVIDE) begin
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_rem  <= ge ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
        if (load_skip) begin
            r_o_average  <= r_avg;
            r_o_accepted <= 1'b0;
            r_o_full     <= full;
        end else if (load_done) begin
            r_o_average  <= r_quo[INTENSITY_W-1:0];
            r_o_accepted <= 1'b1;
            r_o_full     <= full;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_average     = r_o_average;
    assign o_accepted    = r_o_accepted;
    assign o_window_full = r_o_full;

endmodule

FILE: hw/rtl/gma_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the moving average
// depends on gma_pkg, assert_macros.svh and gated_moving_average (bind)
`include "assert_macros.svh"

module gma_checker import gma_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [INTENSITY_W-1:0] o_average,
    input logic                   o_accepted,
    input logic                   o_window_full
);

    logic                   r_seen_full;
    logic                   r_any_acc;
    logic                   r_have_prev;
    logic [INTENSITY_W-1:0] r_last_avg;
    logic                   out_xfer;

    assign out_xfer = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_full <= 1'b0;
            r_any_acc   <= 1'b0;
            r_have_prev <= 1'b0;
            r_last_avg  <= '0;
        end else if (out_xfer) begin
            r_seen_full <= r_seen_full || o_window_full;
            r_any_acc   <= r_any_acc || o_accepted;
            r_have_prev <= 1'b1;
            r_last_avg  <= o_average;
        end
    end

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_average) && $stable(o_accepted) && $stable(o_window_full),
        "stalled result changed")

    `ASSERT_IMPL(a_full_sticky, i_clk, i_rst_n, o_valid && r_seen_full, o_window_full,
        "window full dropped")

    `ASSERT_IMPL(a_skip_keeps_avg, i_clk, i_rst_n, o_valid && !o_accepted && r_have_prev,
        o_average == r_last_avg, "average changed on a gated-out sample")

    `ASSERT_IMPL(a_empty_window, i_clk, i_rst_n, o_valid && !o_accepted && !r_any_acc,
        (o_average == '0) && !o_window_full, "nonzero result from an empty window")

endmodule

bind gated_moving_average gma_checker u_gma_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for gated_moving_average: directed table, then random phases
// at several sample intervals, checked against a local window predictor
// depends on gma_pkg and gated_moving_average
module testbench;
    import gma_pkg::*;

    localparam int WINDOW_DEPTH = 64;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIRECTED_ROWS = 15;

    localparam logic [APB_ADDR_W-1:0] ADDR_INTERVAL = {REG_SAMPLE_INTERVAL, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED   = {~REG_SAMPLE_INTERVAL, 2'b00};
    localparam logic [TIME_W-1:0]     INTERVAL_MAX  = '1;

    typedef struct packed {
        logic [INTENSITY_W-1:0] average;
        logic                   accepted;
        logic                   window_full;
    } t_avg_result;

    typedef struct packed {
        logic [INTENSITY_W-1:0] intensity;
        logic [TIME_W-1:0]      now_ms;
        logic                   known;
        t_avg_result            res;
    } t_row;

    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{16'hFFFF, 32'd0,          1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{16'h0000, 32'd1000,       1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{16'hFFFF, 32'd1001,       1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{16'h1234, 32'd2001,       1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{16'h0000, 32'd2002,       1'b1, '{16'h7FFF, 1'b1, 1'b0}},
        '{16'hAAAA, 32'hFFFF_FFFF,  1'b0, '0},
        '{16'h5555, 32'd5,          1'b0, '0},
        '{16'h8000, 32'd1000,       1'b0, '0},
        '{16'h0001, 32'd500,        1'b0, '0},
        '{16'h7FFF, 32'h8000_0000,  1'b0, '0},
        '{16'hFFFF, 32'h8000_03E8,  1'b0, '0},
        '{16'h0000, 32'h8000_03E9,  1'b0, '0},
        '{16'h5555, 32'h5555_5555,  1'b0, '0},
        '{16'hAAAA, 32'hAAAA_AAAA,  1'b0, '0},
        '{16'hFFFF, 32'hFFFF_FFFE,  1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_valid;
    logic                   o_ready;
    logic [INTENSITY_W-1:0] i_intensity;
    logic [TIME_W-1:0]      i_now_ms;
    logic                   o_valid;
    logic                   i_ready;
    logic [INTENSITY_W-1:0] o_average;
    logic                   o_accepted;
    logic                   o_window_full;

    // predictor state
    logic [INTENSITY_W-1:0] ring [WINDOW_DEPTH];
    logic [5:0]             write_slot;
    logic [6:0]             stored;
    logic [21:0]            window_sum;
    logic [TIME_W-1:0]      last_taken_ms;
    logic [TIME_W-1:0]      interval_ms;

    t_avg_result            pending_averages [$];
    logic [TIME_W-1:0]      clock_ms;
    int                     errors = 0;
    int                     cycle_count = 0;
    int                     hold_left = 0;
    bit                     calm = 1'b0;

    gated_moving_average #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_intensity  (i_intensity),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_average    (o_average),
        .o_accepted   (o_accepted),
        .o_window_full(o_window_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gated_moving_average: mismatch");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    task automatic window_reset();
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            ring[k] = '0;
        end
        write_slot    = '0;
        stored        = '0;
        window_sum    = '0;
        last_taken_ms = '0;
        interval_ms   = INTERVAL_RESET;
    endtask

    task automatic window_update(input logic [INTENSITY_W-1:0] sample,
                                 input logic [TIME_W-1:0] now, output t_avg_result r);
        logic [TIME_W-1:0] elapsed;
        logic [21:0]       quotient;
        elapsed    = now - last_taken_ms;
        r.accepted = elapsed > interval_ms;
        if (r.accepted) begin
            last_taken_ms = now;
            if (stored < WINDOW_DEPTH) begin
                stored = stored + 1'b1;
            end else begin
                window_sum = window_sum - ring[write_slot];
            end
            ring[write_slot] = sample;
            window_sum       = window_sum + sample;
            write_slot       = write_slot + 1'b1;
        end
        quotient = (stored != 0) ? window_sum / stored : '0;
        r.average     = (quotient > 22'hFFFF) ? 16'hFFFF : quotient[15:0];
        r.window_full = stored >= WINDOW_DEPTH;
    endtask

    // entered at a falling edge, returns at the rising edge of the transfer
    task automatic send_item(input logic [INTENSITY_W-1:0] sample, input logic [TIME_W-1:0] now,
                             input bit known, input t_avg_result typed);
        t_avg_result predicted;
        @(negedge i_clk);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_intensity <= sample;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        window_update(sample, now, predicted);
        pending_averages.push_back(known ? typed : predicted);
    endtask

    // entered and left at a falling edge
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr && addr == ADDR_INTERVAL) begin
            interval_ms = data;
        end
        if (!wr && addr == ADDR_INTERVAL && prdata !== interval_ms) begin
            $display("%0t interval readback expected %h actual %h", $time, interval_ms, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_interval(input logic [TIME_W-1:0] value);
        wait_idle();
        apb_access(1'b1, ADDR_INTERVAL, value);
        apb_access(1'b0, ADDR_INTERVAL, '0);
    endtask

    function automatic logic [INTENSITY_W-1:0] pick_intensity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 30) return '1;
        return INTENSITY_W'($urandom);
    endfunction

    task automatic advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            clock_ms = clock_ms + interval_ms + 1 + $urandom_range(0, 3);
        end else if (r < 80) begin
            clock_ms = clock_ms + interval_ms;
        end else if (r < 90) begin
            clock_ms = clock_ms + ((interval_ms == 0) ? 0 : $urandom_range(0, interval_ms));
        end else begin
            clock_ms = $urandom;
        end
    endtask

    task automatic run_random(input int count, input int hold_at);
        for (int k = 0; k < count; k++) begin
            calm = (count >= 100) && (k >= 20) && (k < 70);
            if (k == hold_at) begin
                hold_left = HOLD_CYCLES;
            end
            advance_clock();
            send_item(pick_intensity(), clock_ms, 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    // receiver side
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= !take_break();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_averages.size() == 0) begin
                $display("%0t unexpected result average %h accepted %b full %b",
                         $time, o_average, o_accepted, o_window_full);
                errors++;
            end else begin
                t_avg_result want;
                want = pending_averages.pop_front();
                if (o_average !== want.average) begin
                    $display("%0t average expected %h actual %h", $time, want.average, o_average);
                    errors++;
                end
                if (o_accepted !== want.accepted) begin
                    $display("%0t accepted expected %b actual %b",
                             $time, want.accepted, o_accepted);
                    errors++;
                end
                if (o_window_full !== want.window_full) begin
                    $display("%0t window_full expected %b actual %b",
                             $time, want.window_full, o_window_full);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_intensity = '0;
        i_now_ms    = '0;
        clock_ms    = '0;
        window_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_access(1'b0, ADDR_INTERVAL, '0);

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_item(DIRECTED[k].intensity, DIRECTED[k].now_ms, DIRECTED[k].known,
                      DIRECTED[k].res);
        end
        clock_ms = DIRECTED[DIRECTED_ROWS-1].now_ms;

        // zero interval: fill the window with full scale, then flush it with zeros
        set_interval('0);
        for (int k = 0; k < 2 * WINDOW_DEPTH + 4; k++) begin
            clock_ms = clock_ms + 1;
            send_item((k < WINDOW_DEPTH + 2) ? '1 : '0, clock_ms, 1'b0, '0);
        end
        run_random(100, -1);

        // all-ones interval gates out everything
        set_interval(INTERVAL_MAX);
        run_random(30, -1);

        set_interval($urandom_range(1, 40));
        run_random(100, 40);

        set_interval($urandom);
        run_random(30, -1);

        // write to an unmapped index must leave the interval alone
        wait_idle();
        apb_access(1'b1, ADDR_UNUSED, $urandom);
        apb_access(1'b0, ADDR_INTERVAL, '0);
        set_interval(INTERVAL_RESET);
        run_random(20, -1);

        wait_idle();
        if (errors == 0) begin
            $display("gated_moving_average: match");
        end else begin
            $display("gated_moving_average: mismatch");
        end
        $finish;
    end

endmodule
